// ===== src/pesch_pkg.sv =====
// ----------------------------------------------------------------------------
// pesch_pkg - shared types and constants of the peer scheduler
// Field widths, CSR indexes, status codes, the setup sequencer's states
// and the structs passed between the setup logic and the item pipeline.
// ----------------------------------------------------------------------------
package pesch_pkg;

   // field widths
   localparam int RANK_W  = 11;
   localparam int MYR_W   = 10;
   localparam int LINK_W  = 5;
   localparam int SLICE_W = 40;
   localparam int STEP_W  = 20;
   localparam int LIDX_W  = 4;
   localparam int STAT_W  = 2;
   localparam int OFF_W   = 41;
   localparam int SLOT_W  = 25;
   localparam int MICRO_W = 25;

   // scale limits; the field widths above are sized for these
   localparam int MAX_RANKS = 1024;
   localparam int MAX_LINKS = 16;

   // internal widths
   localparam int SUM_W   = RANK_W + 1;
   localparam int QP_W    = 2 * RANK_W;
   localparam int HALF_W  = SLICE_W / 2;
   localparam int PP_W    = RANK_W + HALF_W;
   localparam int MC_W    = MYR_W + HALF_W;
   localparam int DIV_W   = SLICE_W + 1;
   localparam int DCNT_W  = 6;
   localparam int LIM_RANK_W = 17;
   localparam int LIM_LINK_W = 7;

   // reciprocal numerator, 2^RANK_W
   localparam logic [DIV_W-1:0] RCP_NUM = DIV_W'(2 ** RANK_W);

   // item pipeline stages ahead of the output register
   localparam int PIPE_STAGES = 11;

   // CSR indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MESH_SIZE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MY_RANK     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_BYTES = 3'd4;

   // result status codes
   localparam logic [STAT_W-1:0] ST_XFER   = 2'd0;
   localparam logic [STAT_W-1:0] ST_DUMMY  = 2'd1;
   localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADCFG = 2'd3;

   typedef enum logic [3:0] {
      CFG_GRP_GO,
      CFG_GRP_WAIT,
      CFG_LOC_GO,
      CFG_LOC_WAIT,
      CFG_RND,
      CFG_THR,
      CFG_RCP_GO,
      CFG_RCP_WAIT,
      CFG_CHK_GO,
      CFG_CHK_WAIT,
      CFG_MUL,
      CFG_SUM,
      CFG_READY
   } cfg_state_type;

   // constants worked out once per configuration
   typedef struct packed {
      logic                bad;
      logic [LINK_W-1:0]   link_count;
      logic [RANK_W-1:0]   mesh;
      logic [RANK_W-1:0]   groups;
      logic [RANK_W-1:0]   rounds;
      logic [RANK_W-1:0]   half;
      logic [QP_W-1:0]     thresh;
      logic [RANK_W:0]     recip;     // one bit extra: a single round gives 2^RANK_W
      logic [MYR_W-1:0]    my_group;
      logic [RANK_W-1:0]   loc_idx;
      logic                dummy_all;
      logic [SLICE_W-1:0]  chunk;
      logic [OFF_W-1:0]    my_chunk;
   } cfg_derived_type;

   // one transaction as it moves down the pipeline
   typedef struct packed {
      logic [MICRO_W-1:0]  micro;
      logic                bad;
      logic                over;
      logic [RANK_W-1:0]   qest;
      logic [RANK_W-1:0]   prod;
      logic [RANK_W-1:0]   shift;
      logic [RANK_W-1:0]   color;
      logic [SUM_W-1:0]    t;
      logic [SUM_W-1:0]    up;
      logic [SUM_W-1:0]    dn;
      logic [RANK_W-1:0]   rc;
      logic [RANK_W-1:0]   pos;
      logic [RANK_W-1:0]   upm;
      logic [RANK_W-1:0]   dnm;
      logic                left;
      logic [RANK_W-1:0]   partner;
      logic [RANK_W-1:0]   plocal;
      logic [SUM_W-1:0]    u;
      logic [RANK_W-1:0]   pg;
      logic                dummy;
      logic [RANK_W-1:0]   peer;
      logic [PP_W-1:0]     pp_lo;
      logic [PP_W-1:0]     pp_hi;
   } item_type;

endpackage

// ===== src/pesch_sdiv.sv =====
// ----------------------------------------------------------------------------
// pesch_sdiv - serial restoring divider
// One quotient bit per cycle; a go pulse (re)starts it, done pulses once.
// ----------------------------------------------------------------------------
module pesch_sdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             go,
   input  logic [pesch_pkg::DIV_W-1:0]      dividend,
   input  logic [pesch_pkg::RANK_W-1:0]     divisor,
   output logic                             done,
   output logic [pesch_pkg::DIV_W-1:0]      quotient,
   output logic [pesch_pkg::RANK_W-1:0]     remainder
);
   import pesch_pkg::*;

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [RANK_W-1:0]   rem_ff, rem_in;
   logic [RANK_W-1:0]   dvs_ff, dvs_in;
   logic [RANK_W:0]     trial;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? RANK_W'(trial - {1'b0, dvs_ff}) : trial[RANK_W-1:0];
         cnt_in = cnt_ff + DCNT_W'(1);
         if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/pesch_setup.sv =====
// ----------------------------------------------------------------------------
// pesch_setup - per-configuration constant sequencer
// Reruns after reset and after every CSR write; busy while it works.
// ----------------------------------------------------------------------------
module pesch_setup (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               restart,
   input  logic [pesch_pkg::RANK_W-1:0]       rank_count,
   input  logic [pesch_pkg::RANK_W-1:0]       mesh_size,
   input  logic [pesch_pkg::MYR_W-1:0]        my_rank,
   input  logic [pesch_pkg::LINK_W-1:0]       link_count,
   input  logic [pesch_pkg::SLICE_W-1:0]      slice_bytes,
   output logic                               busy,
   output pesch_pkg::cfg_derived_type         derived
);
   import pesch_pkg::*;

   cfg_state_type       state_ff, state_in;

   logic                div_go, div_done;
   logic [DIV_W-1:0]    div_num, div_quo;
   logic [RANK_W-1:0]   div_den, div_rem;

   logic [RANK_W-1:0]   groups_ff, groups_in;
   logic                rdiv_nz_ff, rdiv_nz_in;
   logic [MYR_W-1:0]    my_group_ff, my_group_in;
   logic [RANK_W-1:0]   loc_ff, loc_in;
   logic [RANK_W-1:0]   rounds_ff, rounds_in;
   logic [RANK_W-1:0]   half_ff, half_in;
   logic                dummy_all_ff, dummy_all_in;
   logic [QP_W-1:0]     thresh_ff, thresh_in;
   logic [RANK_W:0]     recip_ff, recip_in;
   logic [SLICE_W-1:0]  chunk_ff, chunk_in;
   logic [MC_W-1:0]     mc_lo_ff, mc_lo_in;
   logic [MC_W-1:0]     mc_hi_ff, mc_hi_in;
   logic [OFF_W-1:0]    my_chunk_ff, my_chunk_in;
   logic [RANK_W:0]     half_sum;
   logic                cfg_bad;

   pesch_sdiv u_sdiv (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (div_num),
      .divisor   (div_den),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin : next_state
      state_in = state_ff;
      if (restart) begin
         state_in = CFG_GRP_GO;
      end else begin
         case (state_ff)
            CFG_GRP_GO:   state_in = CFG_GRP_WAIT;
            CFG_GRP_WAIT: if (div_done) state_in = CFG_LOC_GO;
            CFG_LOC_GO:   state_in = CFG_LOC_WAIT;
            CFG_LOC_WAIT: if (div_done) state_in = CFG_RND;
            CFG_RND:      state_in = CFG_THR;
            CFG_THR:      state_in = CFG_RCP_GO;
            CFG_RCP_GO:   state_in = CFG_RCP_WAIT;
            CFG_RCP_WAIT: if (div_done) state_in = CFG_CHK_GO;
            CFG_CHK_GO:   state_in = CFG_CHK_WAIT;
            CFG_CHK_WAIT: if (div_done) state_in = CFG_MUL;
            CFG_MUL:      state_in = CFG_SUM;
            CFG_SUM:      state_in = CFG_READY;
            CFG_READY:    state_in = CFG_READY;
            default:      state_in = CFG_GRP_GO;
         endcase
      end
   end

   always_comb begin : outputs
      div_go  = 1'b0;
      div_num = '0;
      div_den = '0;
      busy    = 1'b1;
      case (state_ff)
         CFG_GRP_GO: begin
            div_go  = 1'b1;
            div_num = DIV_W'(rank_count);
            div_den = mesh_size;
         end
         CFG_LOC_GO: begin
            div_go  = 1'b1;
            div_num = DIV_W'(my_rank);
            div_den = mesh_size;
         end
         CFG_RCP_GO: begin
            div_go  = 1'b1;
            div_num = RCP_NUM;
            div_den = rounds_ff;
         end
         CFG_CHK_GO: begin
            // ceiling division: (slice + ranks - 1) / ranks
            div_go  = 1'b1;
            div_num = DIV_W'(slice_bytes) + DIV_W'(rank_count) - DIV_W'(1);
            div_den = rank_count;
         end
         CFG_READY: busy = 1'b0;
         default: ;
      endcase
   end

   always_comb begin : capture
      groups_in    = groups_ff;
      rdiv_nz_in   = rdiv_nz_ff;
      my_group_in  = my_group_ff;
      loc_in       = loc_ff;
      rounds_in    = rounds_ff;
      half_in      = half_ff;
      dummy_all_in = dummy_all_ff;
      thresh_in    = thresh_ff;
      recip_in     = recip_ff;
      chunk_in     = chunk_ff;
      mc_lo_in     = mc_lo_ff;
      mc_hi_in     = mc_hi_ff;
      my_chunk_in  = my_chunk_ff;
      half_sum     = {1'b0, groups_ff} + (RANK_W + 1)'(1);
      case (state_ff)
         CFG_GRP_WAIT: if (div_done) begin
            groups_in  = div_quo[RANK_W-1:0];
            rdiv_nz_in = div_rem != '0;
         end
         CFG_LOC_WAIT: if (div_done) begin
            my_group_in = div_quo[MYR_W-1:0];
            loc_in      = div_rem;
         end
         CFG_RND: begin
            // odd group counts get a dummy group, so rounds = groups then
            if (groups_ff <= RANK_W'(1)) begin
               rounds_in = '0;
            end else if (!groups_ff[0]) begin
               rounds_in = groups_ff - RANK_W'(1);
            end else begin
               rounds_in = groups_ff;
            end
            half_in      = half_sum[RANK_W:1];
            dummy_all_in = (groups_ff <= RANK_W'(1)) ||
                           (RANK_W'(my_group_ff) >= groups_ff);
         end
         CFG_THR: thresh_in = QP_W'(mesh_size) * QP_W'(rounds_ff);
         CFG_RCP_WAIT: if (div_done) begin
            recip_in = div_quo[RANK_W:0];
         end
         CFG_CHK_WAIT: if (div_done) begin
            chunk_in = div_quo[SLICE_W-1:0];
         end
         CFG_MUL: begin
            mc_lo_in = MC_W'(my_rank) * MC_W'(chunk_ff[HALF_W-1:0]);
            mc_hi_in = MC_W'(my_rank) * MC_W'(chunk_ff[SLICE_W-1:HALF_W]);
         end
         CFG_SUM: my_chunk_in = OFF_W'({mc_hi_ff, {HALF_W{1'b0}}}) + OFF_W'(mc_lo_ff);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CFG_GRP_GO;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      groups_ff    <= groups_in;
      rdiv_nz_ff   <= rdiv_nz_in;
      my_group_ff  <= my_group_in;
      loc_ff       <= loc_in;
      rounds_ff    <= rounds_in;
      half_ff      <= half_in;
      dummy_all_ff <= dummy_all_in;
      thresh_ff    <= thresh_in;
      recip_ff     <= recip_in;
      chunk_ff     <= chunk_in;
      mc_lo_ff     <= mc_lo_in;
      mc_hi_ff     <= mc_hi_in;
      my_chunk_ff  <= my_chunk_in;
   end

   assign cfg_bad = (mesh_size == '0) || (rank_count == '0) || rdiv_nz_ff ||
                    (LIM_RANK_W'(rank_count) > LIM_RANK_W'(MAX_RANKS)) ||
                    (link_count == '0) ||
                    (LIM_LINK_W'(link_count) > LIM_LINK_W'(MAX_LINKS));

   always_comb begin
      derived.bad        = cfg_bad;
      derived.link_count = link_count;
      derived.mesh       = mesh_size;
      derived.groups     = groups_ff;
      derived.rounds     = rounds_ff;
      derived.half       = half_ff;
      derived.thresh     = thresh_ff;
      derived.recip      = recip_ff;
      derived.my_group   = my_group_ff;
      derived.loc_idx    = loc_ff;
      derived.dummy_all  = dummy_all_ff;
      derived.chunk      = chunk_ff;
      derived.my_chunk   = my_chunk_ff;
   end

endmodule

// ===== src/pesch_pipe.sv =====
// ----------------------------------------------------------------------------
// pesch_pipe - item pipeline
// Micro round, round split, circle pairing, peer rank and chunk offsets.
// ----------------------------------------------------------------------------
module pesch_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [pesch_pkg::STEP_W-1:0]       step,
   input  logic [pesch_pkg::LIDX_W-1:0]       link_index,
   input  pesch_pkg::cfg_derived_type         derived,
   output logic                               rsp_strobe,
   output logic [pesch_pkg::STAT_W-1:0]       rsp_status,
   output logic [pesch_pkg::MYR_W-1:0]        rsp_peer_rank,
   output logic                               rsp_my_side_left,
   output logic [pesch_pkg::OFF_W-1:0]        rsp_peer_chunk_offset,
   output logic [pesch_pkg::OFF_W-1:0]        rsp_my_chunk_offset,
   output logic [pesch_pkg::SLOT_W-1:0]       rsp_notify_slot
);
   import pesch_pkg::*;

   item_type            s_in  [1:PIPE_STAGES];
   item_type            s_ff  [1:PIPE_STAGES];
   logic                vld_ff [1:PIPE_STAGES];

   logic [QP_W-1:0]     qmul;
   logic [QP_W-1:0]     rmul;
   logic [RANK_W-1:0]   rem4;
   logic [SUM_W-1:0]    tm6;
   logic [SUM_W-1:0]    um9;
   logic [QP_W-1:0]     pmul10;
   logic [OFF_W-1:0]    peer_off;

   logic                strobe_ff;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [MYR_W-1:0]    peer_ff, peer_in;
   logic                left_ff, left_in;
   logic [OFF_W-1:0]    poff_ff, poff_in;
   logic [OFF_W-1:0]    moff_ff, moff_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   always_comb begin
      // micro round and link check
      s_in[1]       = '0;
      s_in[1].micro = MICRO_W'(step) * MICRO_W'(derived.link_count) +
                      MICRO_W'(link_index);
      s_in[1].bad   = derived.bad || (LINK_W'(link_index) >= derived.link_count);

      // beyond-last-shift test and quotient estimate
      s_in[2]      = s_ff[1];
      s_in[2].over = (derived.rounds != '0) &&
                     (s_ff[1].micro >= MICRO_W'(derived.thresh));
      qmul         = QP_W'(s_ff[1].micro[RANK_W-1:0]) * QP_W'(derived.recip);
      s_in[2].qest = qmul[QP_W-1:RANK_W];

      // estimate times divisor
      s_in[3]      = s_ff[2];
      rmul         = QP_W'(s_ff[2].qest) * QP_W'(derived.rounds);
      s_in[3].prod = rmul[RANK_W-1:0];

      // one-step correction gives shift and colour round
      s_in[4] = s_ff[3];
      rem4    = s_ff[3].micro[RANK_W-1:0] - s_ff[3].prod;
      if (rem4 >= derived.rounds) begin
         s_in[4].shift = s_ff[3].qest + RANK_W'(1);
         s_in[4].color = rem4 - derived.rounds;
      end else begin
         s_in[4].shift = s_ff[3].qest;
         s_in[4].color = rem4;
      end

      // circle position sum, local index candidates
      s_in[5]    = s_ff[4];
      s_in[5].t  = SUM_W'(RANK_W'(derived.my_group) - RANK_W'(1)) +
                   SUM_W'(s_ff[4].color);
      s_in[5].up = SUM_W'(derived.loc_idx) + SUM_W'(s_ff[4].shift);
      s_in[5].dn = SUM_W'(derived.loc_idx) + SUM_W'(derived.mesh) -
                   SUM_W'(s_ff[4].shift);
      s_in[5].rc = derived.rounds - s_ff[4].color;

      // wrap the sums
      s_in[6] = s_ff[5];
      tm6     = (s_ff[5].t >= SUM_W'(derived.rounds)) ?
                s_ff[5].t - SUM_W'(derived.rounds) : s_ff[5].t;
      s_in[6].pos = (derived.my_group == '0) ? '0 : tm6[RANK_W-1:0] + RANK_W'(1);
      s_in[6].upm = (s_ff[5].up >= SUM_W'(derived.mesh)) ?
                    RANK_W'(s_ff[5].up - SUM_W'(derived.mesh)) : s_ff[5].up[RANK_W-1:0];
      s_in[6].dnm = (s_ff[5].dn >= SUM_W'(derived.mesh)) ?
                    RANK_W'(s_ff[5].dn - SUM_W'(derived.mesh)) : s_ff[5].dn[RANK_W-1:0];

      // side, partner slot, peer local index
      s_in[7]         = s_ff[6];
      s_in[7].left    = s_ff[6].pos < derived.half;
      s_in[7].partner = derived.rounds - s_ff[6].pos;
      s_in[7].plocal  = (s_ff[6].pos < derived.half) ? s_ff[6].upm : s_ff[6].dnm;

      // group at the partner slot, sum
      s_in[8]   = s_ff[7];
      s_in[8].u = SUM_W'(s_ff[7].partner - RANK_W'(1)) + SUM_W'(s_ff[7].rc);

      // group at the partner slot, wrap; the dummy group means no partner
      s_in[9]     = s_ff[8];
      um9         = (s_ff[8].u >= SUM_W'(derived.rounds)) ?
                    s_ff[8].u - SUM_W'(derived.rounds) : s_ff[8].u;
      s_in[9].pg  = (s_ff[8].partner == '0) ? '0 : um9[RANK_W-1:0] + RANK_W'(1);
      s_in[9].dummy = derived.dummy_all || (s_in[9].pg >= derived.groups);

      // peer global rank
      s_in[10]      = s_ff[9];
      pmul10        = QP_W'(s_ff[9].pg) * QP_W'(derived.mesh) + QP_W'(s_ff[9].plocal);
      s_in[10].peer = pmul10[RANK_W-1:0];

      // peer offset partial products
      s_in[11]       = s_ff[10];
      s_in[11].pp_lo = PP_W'(s_ff[10].peer) * PP_W'(derived.chunk[HALF_W-1:0]);
      s_in[11].pp_hi = PP_W'(s_ff[10].peer) * PP_W'(derived.chunk[SLICE_W-1:HALF_W]);
   end

   always_comb begin
      peer_off = OFF_W'({s_ff[PIPE_STAGES].pp_hi, {HALF_W{1'b0}}}) +
                 OFF_W'(s_ff[PIPE_STAGES].pp_lo);
      status_in = ST_XFER;
      peer_in   = '0;
      left_in   = 1'b0;
      poff_in   = '0;
      moff_in   = '0;
      slot_in   = '0;
      if (s_ff[PIPE_STAGES].bad) begin
         status_in = ST_BADCFG;
      end else if (s_ff[PIPE_STAGES].over) begin
         status_in = ST_BEYOND;
      end else if (s_ff[PIPE_STAGES].dummy) begin
         status_in = ST_DUMMY;
      end else begin
         peer_in = s_ff[PIPE_STAGES].peer[MYR_W-1:0];
         left_in = s_ff[PIPE_STAGES].left;
         poff_in = peer_off;
         moff_in = derived.my_chunk;
         slot_in = SLOT_W'(s_ff[PIPE_STAGES].micro + MICRO_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= PIPE_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         vld_ff[1] <= accept;
         for (int k = 2; k <= PIPE_STAGES; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         strobe_ff <= vld_ff[PIPE_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= PIPE_STAGES; k++) begin
         s_ff[k] <= s_in[k];
      end
      status_ff <= status_in;
      peer_ff   <= peer_in;
      left_ff   <= left_in;
      poff_ff   <= poff_in;
      moff_ff   <= moff_in;
      slot_ff   <= slot_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_peer_rank         = peer_ff;
   assign rsp_my_side_left      = left_ff;
   assign rsp_peer_chunk_offset = poff_ff;
   assign rsp_my_chunk_offset   = moff_ff;
   assign rsp_notify_slot       = slot_ff;

endmodule

// ===== src/pairwise_exchange_peer_scheduler_core.sv =====
// An accepted transaction (start high, busy low) runs through the item pipeline
// stages and the output register to its rsp_strobe cycle. Throughput: one
// transaction per cycle while busy is low; results are never held back by the
// receiver. After reset and after every CSR write, busy stays high while the
// setup sequencer's serial divider (one bit a cycle) works out the
// per-configuration constants. Reset is synchronous and active high.
// ----------------------------------------------------------------------------
// pairwise_exchange_peer_scheduler_core - peer schedule for pairwise exchange
// Maps (step, link) to the peer rank of a circle-method group pairing plus
// the chunk offsets and notify slot for the descriptor engine.
// ----------------------------------------------------------------------------
module pairwise_exchange_peer_scheduler_core (
   input  logic                                clock,
   input  logic                                reset,
   // command side
   input  logic                                start,
   output logic                                busy,
   input  logic [pesch_pkg::STEP_W-1:0]        req_step,
   input  logic [pesch_pkg::LIDX_W-1:0]        req_link_index,
   // result side
   output logic                                rsp_strobe,
   output logic [pesch_pkg::STAT_W-1:0]        rsp_status,
   output logic [pesch_pkg::MYR_W-1:0]         rsp_peer_rank,
   output logic                                rsp_my_side_left,
   output logic [pesch_pkg::OFF_W-1:0]         rsp_peer_chunk_offset,
   output logic [pesch_pkg::OFF_W-1:0]         rsp_my_chunk_offset,
   output logic [pesch_pkg::SLOT_W-1:0]        rsp_notify_slot,
   // CSR write port
   input  logic                                csr_wr_en,
   input  logic [pesch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pesch_pkg::SLICE_W-1:0]       csr_wdata
);
   import pesch_pkg::*;

   // CSRs, held at their reset values until written
   logic [RANK_W-1:0]   rank_count_ff, rank_count_in;
   logic [RANK_W-1:0]   mesh_size_ff, mesh_size_in;
   logic [MYR_W-1:0]    my_rank_ff, my_rank_in;
   logic [LINK_W-1:0]   link_count_ff, link_count_in;
   logic [SLICE_W-1:0]  slice_bytes_ff, slice_bytes_in;

   logic                setup_busy;
   logic                accept;
   cfg_derived_type     derived;

   // CSR decode; writes to unused indexes fall through and change no CSR
   always_comb begin
      rank_count_in  = rank_count_ff;
      mesh_size_in   = mesh_size_ff;
      my_rank_in     = my_rank_ff;
      link_count_in  = link_count_ff;
      slice_bytes_in = slice_bytes_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RANK_COUNT:  rank_count_in  = csr_wdata[RANK_W-1:0];
            CSR_MESH_SIZE:   mesh_size_in   = csr_wdata[RANK_W-1:0];
            CSR_MY_RANK:     my_rank_in     = csr_wdata[MYR_W-1:0];
            CSR_LINK_COUNT:  link_count_in  = csr_wdata[LINK_W-1:0];
            CSR_SLICE_BYTES: slice_bytes_in = csr_wdata[SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff  <= RANK_W'(1);
         mesh_size_ff   <= RANK_W'(1);
         my_rank_ff     <= '0;
         link_count_ff  <= LINK_W'(1);
         slice_bytes_ff <= '0;
      end else begin
         rank_count_ff  <= rank_count_in;
         mesh_size_ff   <= mesh_size_in;
         my_rank_ff     <= my_rank_in;
         link_count_ff  <= link_count_in;
         slice_bytes_ff <= slice_bytes_in;
      end
   end

   // Setup: group count, rounds, own group/local index, reciprocal of the
   // round count, chunk size and own offset. Any CSR write restarts it.
   pesch_setup u_setup (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_wr_en),
      .rank_count  (rank_count_ff),
      .mesh_size   (mesh_size_ff),
      .my_rank     (my_rank_ff),
      .link_count  (link_count_ff),
      .slice_bytes (slice_bytes_ff),
      .busy        (setup_busy),
      .derived     (derived)
   );

   // A transaction is taken whenever start is high and setup is done; the
   // pipeline itself never pushes back, so busy comes from setup alone.
   assign busy   = setup_busy;
   assign accept = start && !setup_busy;

   // Item pipeline: micro round -> round split via reciprocal estimate and
   // one correction -> circle pairing -> peer rank -> offsets -> result.
   pesch_pipe u_pipe (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (accept),
      .step                  (req_step),
      .link_index            (req_link_index),
      .derived               (derived),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_peer_rank         (rsp_peer_rank),
      .rsp_my_side_left      (rsp_my_side_left),
      .rsp_peer_chunk_offset (rsp_peer_chunk_offset),
      .rsp_my_chunk_offset   (rsp_my_chunk_offset),
      .rsp_notify_slot       (rsp_notify_slot)
   );

endmodule
